@@ rtl/lpde_pkg.sv @@
package lpde_pkg;

    localparam int DIST_BITS      = 48;
    localparam int TOL_BITS       = 16;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] CFG_METRIC_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BEST_SO_FAR = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE   = 2'd2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SQ_EUCLID  = 2'd0,
        MODE_MANHATTAN  = 2'd1,
        MODE_CHEBYSHEV  = 2'd2,
        MODE_AVERAGE    = 2'd3
    } metric_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 abandoned;
    } result_t;

endpackage

@@ rtl/lpde_if.sv @@
interface lpde_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic                          last_item;

    modport source (output valid, output sample_a, output sample_b, output last_item,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input last_item,
                    output ready);
endinterface

interface lpde_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] distance;
    logic        abandoned;

    modport source (output valid, output distance, output abandoned, input ready);
    modport sink   (input valid, input distance, input abandoned, output ready);
endinterface

@@ rtl/lpde_diff.sv @@
module lpde_diff #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lpde_in_if.sink                        samples,
    output logic                           diff_valid,
    input  logic                           diff_ready,
    output logic [SAMPLE_BITS:0]           diff_abs,
    output logic [2*(SAMPLE_BITS+1)-1:0]   diff_sq,
    output logic                           diff_last
);

    localparam int AW = SAMPLE_BITS + 1;
    localparam int QW = 2 * AW;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SAMPLE_BITS-1:0] b_reg;
    logic                          in_last_reg;

    logic                          sq_valid_reg;
    logic [AW-1:0]                 abs_reg;
    logic [QW-1:0]                 sq_reg;
    logic                          sq_last_reg;

    logic                          sq_free;
    logic                          in_free;
    logic signed [AW-1:0]          diff;
    logic [AW-1:0]                 abs_next;
    logic [QW-1:0]                 sq_next;

    assign sq_free       = !sq_valid_reg || diff_ready;
    assign in_free       = !in_valid_reg || sq_free;
    assign samples.ready = in_free;

    always_comb
    begin
        diff     = {a_reg[SAMPLE_BITS-1], a_reg} - {b_reg[SAMPLE_BITS-1], b_reg};
        abs_next = diff[AW-1] ? AW'(-diff) : AW'(diff);
        sq_next  = QW'(abs_next) * QW'(abs_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= samples.valid;
            if (sq_free)
                sq_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && samples.valid)
        begin
            a_reg       <= samples.sample_a;
            b_reg       <= samples.sample_b;
            in_last_reg <= samples.last_item;
        end
        if (sq_free && in_valid_reg)
        begin
            abs_reg     <= abs_next;
            sq_reg      <= sq_next;
            sq_last_reg <= in_last_reg;
        end
    end

    assign diff_valid = sq_valid_reg;
    assign diff_abs   = abs_reg;
    assign diff_sq    = sq_reg;
    assign diff_last  = sq_last_reg;

endmodule

@@ rtl/lp_distance_early_abandon.sv @@
// Early-abandon distance over a stream of sample pairs.
//
// samples: one request per pair (sample_a, sample_b, last_item), valid/ready.
// result:  one request per finished series (distance, abandoned), valid/ready.
// cfg:     cfg_write/cfg_index/cfg_data; 0 metric mode, 1 best-so-far bound,
//          2 tolerance. Write only while the block is idle.
//
// Throughput: one pair per cycle while no result waits on a stalled result port;
// the running sum, running max and abandon compare are combinational, after a
// registered diff/square stage. A result passes the input register, the square
// register and the result register before it shows on result.valid.
// After an abandon the remaining pairs of the series are accepted and dropped.
// Reset clears the series state, sets mode 0, bound all ones, tolerance 0.
// When result is stalled, pairs that make no result keep flowing; a pair that
// would make a result waits in the pipeline and backpressure reaches samples.
module lp_distance_early_abandon #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    lpde_in_if.sink                               samples,
    lpde_out_if.source                            result,
    input  logic                                  cfg_write,
    input  logic [lpde_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lpde_pkg::DIST_BITS-1:0]        cfg_data
);

    import lpde_pkg::*;

    localparam int AW   = SAMPLE_BITS + 1;
    localparam int QW   = 2 * AW;
    localparam int WIDE = (SUM_BITS > QW ? SUM_BITS : QW) + 1;
    localparam int MW   = (AW > TOL_BITS ? AW : TOL_BITS) + 1;
    localparam int DW   = (SUM_BITS > AW ? SUM_BITS : AW) + 1;
    localparam int CW   = (DW > DIST_BITS + 1 ? DW : DIST_BITS + 1) + 1;

    metric_t                mode_reg;
    logic [DIST_BITS-1:0]   bsf_reg;
    logic [TOL_BITS-1:0]    tol_reg;
    logic [DIST_BITS:0]     bound_reg;

    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [AW-1:0]          max_reg;
    logic [AW-1:0]          max_next;
    logic                   skip_reg;

    logic                   res_valid_reg;
    result_t                res_reg;

    logic                   diff_valid;
    logic                   diff_ready;
    logic [AW-1:0]          diff_abs;
    logic [QW-1:0]          diff_sq;
    logic                   diff_last;

    logic [WIDE-1:0]        sum_limit;
    logic [WIDE-1:0]        add_term;
    logic [WIDE-1:0]        add_total;
    logic [DW-1:0]          dist_val;
    logic [CW-1:0]          dist_ext;
    logic                   abandon;
    logic                   emit;
    logic                   fire;

    lpde_diff #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_diff (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .diff_valid (diff_valid),
        .diff_ready (diff_ready),
        .diff_abs   (diff_abs),
        .diff_sq    (diff_sq),
        .diff_last  (diff_last)
    );

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SQ_EUCLID;
            bsf_reg   <= DIST_MAX;
            tol_reg   <= '0;
            bound_reg <= {1'b0, DIST_MAX};
        end
        else
        begin
            bound_reg <= {1'b0, bsf_reg} + (DIST_BITS + 1)'(tol_reg);
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_METRIC_MODE: mode_reg <= metric_t'(cfg_data[MODE_BITS-1:0]);
                    CFG_BEST_SO_FAR: bsf_reg  <= cfg_data;
                    CFG_TOLERANCE:   tol_reg  <= cfg_data[TOL_BITS-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // accumulate, running max, abandon test
    always_comb
    begin
        sum_limit = WIDE'({SUM_BITS{1'b1}});
        add_term  = (mode_reg == MODE_SQ_EUCLID) ? WIDE'(diff_sq) : WIDE'(diff_abs);
        add_total = WIDE'(sum_reg) + add_term;

        unique case (mode_reg)
            MODE_SQ_EUCLID, MODE_MANHATTAN, MODE_AVERAGE:
                sum_next = (add_total > sum_limit) ? sum_limit[SUM_BITS-1:0]
                                                   : add_total[SUM_BITS-1:0];
            default:
                sum_next = sum_reg;
        endcase

        if ((mode_reg == MODE_CHEBYSHEV || mode_reg == MODE_AVERAGE) &&
            (MW'(diff_abs) > MW'(max_reg) + MW'(tol_reg)))
            max_next = diff_abs;
        else
            max_next = max_reg;

        unique case (mode_reg)
            MODE_CHEBYSHEV: dist_val = DW'(max_next);
            MODE_AVERAGE:   dist_val = (DW'(sum_next) + DW'(max_next)) >> 1;
            default:        dist_val = DW'(sum_next);
        endcase

        dist_ext = CW'(dist_val);
        abandon  = (mode_reg != MODE_AVERAGE) && (dist_ext > CW'(bound_reg));
        emit     = !skip_reg && (abandon || diff_last);
    end

    assign diff_ready = !emit || !res_valid_reg || result.ready;
    assign fire       = diff_valid && diff_ready;

    // series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            max_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (diff_last)
            begin
                sum_reg  <= '0;
                max_reg  <= '0;
                skip_reg <= 1'b0;
            end
            else if (!skip_reg)
            begin
                sum_reg  <= sum_next;
                max_reg  <= max_next;
                skip_reg <= abandon;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (fire && emit)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            res_reg.distance  <= (dist_ext > CW'(DIST_MAX)) ? DIST_MAX
                                                             : dist_ext[DIST_BITS-1:0];
            res_reg.abandoned <= abandon;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.distance  = res_reg.distance;
    assign result.abandoned = res_reg.abandoned;

endmodule

@@ dv/lp_distance_early_abandon_test.sv @@
`timescale 1ns / 1ps

module lp_distance_early_abandon_test;

    import lpde_pkg::*;

    localparam int SAMPLE_W      = 16;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 1000;
    localparam int LONG_PAIRS    = 64;
    localparam int RANDOM_PAIRS  = 1720;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        logic                last;
    } pair_t;

    typedef enum int {
        PAIR_FULL,
        PAIR_CLOSE,
        PAIR_SMALL,
        PAIR_EDGE
    } pair_style_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_ALTERNATE,
        STALL_LONG
    } stall_style_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [DIST_BITS-1:0]      cfg_data;

    lpde_in_if #(.SAMPLE_BITS(SAMPLE_W)) samples_ch();
    lpde_out_if                          result_ch();

    lp_distance_early_abandon #(
        .SAMPLE_BITS(SAMPLE_W),
        .SUM_BITS   (48)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_ch),
        .result   (result_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // distance model state
    metric_t              cur_mode  = MODE_SQ_EUCLID;
    logic [DIST_BITS-1:0] cur_bound = DIST_MAX;
    logic [TOL_BITS-1:0]  cur_tol   = '0;
    logic [DIST_BITS-1:0] run_sum   = '0;
    logic [SAMPLE_W:0]    run_max   = '0;
    logic                 skip_series = 1'b0;

    result_t     expected_distances[$];
    pair_t       pairs_to_send[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    logic        pair_taken     = 1'b0;
    int          gap_left       = 0;
    int          burst_left     = 0;
    int          stall_left     = 0;
    int          style_left     = 0;
    stall_style_t stall_style   = STALL_NONE;
    int          series_left    = 0;
    pair_style_t pair_style     = PAIR_FULL;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void clear_series();
        run_sum     = '0;
        run_max     = '0;
        skip_series = 1'b0;
    endfunction

    function automatic void accumulate_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                            logic last);
        int          d;
        logic [63:0] ad;
        logic [63:0] incr;
        logic [63:0] total;
        logic [63:0] dist_val;
        logic        over;
        result_t     res;
        if (skip_series)
        begin
            if (last)
                clear_series();
            return;
        end
        d  = int'($signed(a)) - int'($signed(b));
        ad = 64'(d < 0 ? -d : d);
        if (cur_mode != MODE_CHEBYSHEV)
        begin
            incr    = (cur_mode == MODE_SQ_EUCLID) ? ad * ad : ad;
            total   = 64'(run_sum) + incr;
            run_sum = (total > 64'(DIST_MAX)) ? DIST_MAX : total[DIST_BITS-1:0];
        end
        if ((cur_mode == MODE_CHEBYSHEV || cur_mode == MODE_AVERAGE) &&
            ad > 64'(run_max) + 64'(cur_tol))
            run_max = ad[SAMPLE_W:0];
        case (cur_mode)
            MODE_CHEBYSHEV:
                dist_val = 64'(run_max);
            MODE_AVERAGE:
                dist_val = (64'(run_sum) >> 1) + (64'(run_max) >> 1)
                         + ((64'(run_sum[0]) + 64'(run_max[0])) >> 1);
            default:
                dist_val = 64'(run_sum);
        endcase
        over = (cur_mode != MODE_AVERAGE) && dist_val > 64'(cur_bound)
            && dist_val - 64'(cur_bound) > 64'(cur_tol);
        if (!over && !last)
            return;
        res.distance  = dist_val[DIST_BITS-1:0];
        res.abandoned = over;
        expected_distances.push_back(res);
        if (last)
            clear_series();
        else
            skip_series = 1'b1;
    endfunction

    task automatic flag_mismatch(string what, logic [DIST_BITS-1:0] got,
                                 logic [DIST_BITS-1:0] want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // request monitor, checker and model update
    always @(posedge clk)
    begin
        result_t want;
        logic    took_result;
        if (!rst_n)
        begin
            pair_taken = 1'b0;
        end
        else
        begin
            pair_taken  = samples_ch.valid && samples_ch.ready;
            took_result = result_ch.valid && result_ch.ready;
            if (pair_taken)
                accumulate_pair(samples_ch.sample_a, samples_ch.sample_b, samples_ch.last_item);
            if (took_result)
            begin
                if (expected_distances.size() == 0)
                begin
                    flag_mismatch("unexpected result", result_ch.distance, '0);
                end
                else
                begin
                    want = expected_distances.pop_front();
                    if (result_ch.distance !== want.distance)
                        flag_mismatch("distance", result_ch.distance, want.distance);
                    if (result_ch.abandoned !== want.abandoned)
                        flag_mismatch("abandoned", DIST_BITS'(result_ch.abandoned),
                                      DIST_BITS'(want.abandoned));
                end
            end
            idle_cycles = (pair_taken || took_result) ? 0 : idle_cycles + 1;
        end
    end

    // sample driver: bursts with random gaps
    always @(negedge clk)
    begin
        pair_t nxt;
        logic  show;
        if (rst_n && (!samples_ch.valid || pair_taken))
        begin
            show = 1'b0;
            nxt  = '0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pairs_to_send.size() > 0)
            begin
                nxt  = pairs_to_send.pop_front();
                show = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    burst_left = $urandom_range(100, 300);
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
            end
            samples_ch.valid <= show;
            if (show)
            begin
                samples_ch.sample_a  <= nxt.a;
                samples_ch.sample_b  <= nxt.b;
                samples_ch.last_item <= nxt.last;
            end
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(50, 400);
        end
        else
        begin
            style_left--;
        end
        if (stall_left == 0)
        begin
            case (stall_style)
                STALL_LIGHT:
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 3);
                STALL_ALTERNATE:
                    if ($urandom_range(0, 1) == 1)
                        stall_left = 1;
                STALL_LONG:
                    if ($urandom_range(0, 15) == 0)
                        stall_left = $urandom_range(5, 24);
                default:
                    stall_left = 0;
            endcase
        end
        result_ch.ready <= (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    function automatic void queue_pair(int a, int b, bit last);
        pair_t p;
        p.a    = SAMPLE_W'(a);
        p.b    = SAMPLE_W'(b);
        p.last = last;
        pairs_to_send.push_back(p);
    endfunction

    function automatic int edge_sample();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic void queue_random_pairs(int count);
        int a;
        int b;
        repeat (count)
        begin
            if (series_left == 0)
            begin
                series_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                           : $urandom_range(1, 16);
                pair_style  = pair_style_t'($urandom_range(0, 3));
            end
            case (pair_style)
                PAIR_CLOSE:
                begin
                    a = int'($signed(16'($urandom)));
                    b = a + int'($urandom_range(0, 128)) - 64;
                end
                PAIR_SMALL:
                begin
                    a = int'($urandom_range(0, 511)) - 256;
                    b = int'($urandom_range(0, 511)) - 256;
                end
                PAIR_EDGE:
                begin
                    a = edge_sample();
                    b = edge_sample();
                end
                default:
                begin
                    a = int'($signed(16'($urandom)));
                    b = int'($signed(16'($urandom)));
                end
            endcase
            series_left--;
            queue_pair(a, b, series_left == 0);
        end
    endfunction

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [DIST_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_METRIC_MODE: cur_mode  = metric_t'(data[MODE_BITS-1:0]);
            CFG_BEST_SO_FAR: cur_bound = data;
            CFG_TOLERANCE:   cur_tol   = data[TOL_BITS-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pairs_to_send.size() != 0 || samples_ch.valid || expected_distances.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic pick_config(bit write_all);
        logic [DIST_BITS-1:0] data;
        if (write_all || $urandom_range(0, 1) == 1)
        begin
            data = ($urandom_range(0, 5) == 0) ? DIST_BITS'({$urandom, $urandom})
                                               : DIST_BITS'($urandom_range(0, 3));
            write_reg(CFG_METRIC_MODE, data);
        end
        if (write_all || $urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 5))
                0: data = '0;
                1: data = DIST_MAX;
                2: data = DIST_MAX - DIST_BITS'($urandom_range(0, 70000));
                default: data = DIST_BITS'({$urandom, $urandom}) >> $urandom_range(4, 47);
            endcase
            write_reg(CFG_BEST_SO_FAR, data);
        end
        if (write_all || $urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 4))
                0: data = '0;
                1: data = DIST_BITS'(16'hFFFF);
                2: data = DIST_BITS'($urandom_range(0, 15));
                3: data = DIST_BITS'($urandom_range(0, 65535));
                default: data = DIST_BITS'({$urandom, $urandom});
            endcase
            write_reg(CFG_TOLERANCE, data);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED, DIST_BITS'({$urandom, $urandom}));
    endtask

    initial
    begin
        int phase_len;
        int random_sent;
        bit first_phase;
        rst_n                = 1'b0;
        cfg_write            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        samples_ch.valid     = 1'b0;
        samples_ch.sample_a  = '0;
        samples_ch.sample_b  = '0;
        samples_ch.last_item = 1'b0;
        result_ch.ready      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: squared euclidean, bound all ones
        queue_pair(32767, -32768, 1);
        queue_pair(-32768, 32767, 1);
        queue_pair(0, 0, 1);
        queue_pair(-1, 1, 0);
        queue_pair(5, 5, 1);
        settle();

        // abandon mid-series, skipped tail, abandon on last pair
        write_reg(CFG_METRIC_MODE, DIST_BITS'(MODE_MANHATTAN));
        write_reg(CFG_BEST_SO_FAR, 48'd100);
        write_reg(CFG_TOLERANCE, 48'd5);
        queue_pair(10, 0, 0);
        queue_pair(50, -50, 0);
        queue_pair(1, 2, 0);
        queue_pair(3, 4, 1);
        queue_pair(-100, 100, 1);
        queue_pair(1, 0, 1);
        settle();

        // running max with tolerance slack
        write_reg(CFG_METRIC_MODE, DIST_BITS'(MODE_CHEBYSHEV));
        write_reg(CFG_BEST_SO_FAR, 48'd20);
        queue_pair(0, 10, 0);
        queue_pair(0, 14, 0);
        queue_pair(0, 16, 0);
        queue_pair(0, -30, 1);
        settle();

        // average never abandons
        write_reg(CFG_METRIC_MODE, DIST_BITS'(MODE_AVERAGE));
        write_reg(CFG_BEST_SO_FAR, '0);
        write_reg(CFG_TOLERANCE, '0);
        queue_pair(3, 0, 0);
        queue_pair(0, 4, 1);
        settle();

        // mode switch inside one series
        write_reg(CFG_METRIC_MODE, DIST_BITS'(MODE_SQ_EUCLID));
        write_reg(CFG_BEST_SO_FAR, DIST_MAX);
        queue_pair(2, 0, 0);
        settle();
        write_reg(CFG_METRIC_MODE, DIST_BITS'(MODE_MANHATTAN));
        queue_pair(0, 3, 0);
        settle();
        write_reg(CFG_METRIC_MODE, DIST_BITS'(MODE_CHEBYSHEV));
        queue_pair(5, 0, 1);
        settle();

        // masked writes and the unused index
        write_reg(CFG_UNUSED, DIST_MAX);
        write_reg(CFG_METRIC_MODE, 48'hFFFF_FFFF_FFFC);
        write_reg(CFG_TOLERANCE, 48'hABCD_0000_0007);

        // long full-scale series
        for (int i = 0; i < LONG_PAIRS; i++)
            queue_pair(i[0] ? 32767 : -32768, i[0] ? -32768 : 32767, i == LONG_PAIRS - 1);
        settle();

        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_PAIRS)
        begin
            pick_config(first_phase);
            first_phase = 1'b0;
            phase_len   = $urandom_range(20, 150);
            queue_random_pairs(phase_len);
            random_sent += phase_len;
            settle();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

endmodule
